// ===== rtl/core/pmc_pkg.sv =====
`timescale 1ns / 1ps
package pmc_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREMULTIPLY  = 2'd2;

   localparam int CFG_DIM_W   = 13;
   localparam int CH_W        = 8;
   localparam int SUM_W       = 10;
   localparam int NUM_CH      = 4;
   localparam int CH_ALPHA    = 3;
   localparam int OUT_LEVEL_W = 4;
   localparam int OUT_POS_W   = 12;

   // channel 0 red, 1 green, 2 blue, 3 alpha
   typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_type;

   typedef struct packed {
      logic                 restart;
      logic [CFG_DIM_W-1:0] width;
      logic [CFG_DIM_W-1:0] height;
   } size_cfg_type;

   typedef struct packed {
      logic [OUT_LEVEL_W-1:0] mip_level;
      logic [OUT_POS_W-1:0]   pixel_x;
      logic [OUT_POS_W-1:0]   pixel_y;
      pixel_type              pixel;
      logic                   last_of_run;
      logic                   chain_done;
   } result_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_LOOK,
      BS_EMIT
   } back_state_type;

endpackage

// ===== rtl/core/pmc_ram.sv =====
`timescale 1ns / 1ps
module pmc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/pmc_front.sv =====
`timescale 1ns / 1ps
module pmc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              premultiply,
   input  logic              hold,
   input  logic              in_valid,
   input  pmc_pkg::pixel_type in_pixel,
   output logic              in_ready,
   output logic              out_valid,
   output pmc_pkg::pixel_type out_pixel,
   input  logic              out_ready
);
   import pmc_pkg::*;

   logic      valid_ff, valid_in;
   pixel_type pixel_ff, pixel_in;

   assign in_ready = !hold && (!valid_ff || out_ready);

   // premultiply colors: floor(c*a/255) via exact reciprocal form
   always_comb begin
      logic [2*CH_W-1:0] prod;
      logic [2*CH_W:0]   acc;
      pixel_in = in_pixel;
      for (int i = 0; i < CH_ALPHA; i++) begin
         prod = (2*CH_W)'(in_pixel[i]) * (2*CH_W)'(in_pixel[CH_ALPHA]);
         acc  = {1'b0, prod} + {{(CH_W+1){1'b0}}, prod[2*CH_W-1:CH_W]} + 1'b1;
         if (premultiply) begin
            pixel_in[i] = acc[2*CH_W-1:CH_W];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
endmodule

// ===== rtl/core/pmc_queue.sv =====
`timescale 1ns / 1ps
module pmc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pmc_pkg::pixel_type in_pixel,
   output logic              in_ready,
   output logic              out_valid,
   output pmc_pkg::pixel_type out_pixel,
   input  logic              out_ready
);
   import pmc_pkg::*;

   logic      [1:0] count_ff, count_in;
   logic            wr_ptr_ff, rd_ptr_ff;
   pixel_type       slot_ff [2];
   logic            push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_pixel = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // advance pointers and store requests
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_pixel;
      end
   end
endmodule

// ===== rtl/core/pmc_back.sv =====
`timescale 1ns / 1ps
module pmc_back #(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmc_pkg::size_cfg_type size_cfg,
   output logic                  busy,
   input  logic                  in_valid,
   input  pmc_pkg::pixel_type    in_pixel,
   output logic                  in_ready,
   output logic                  res_valid,
   output pmc_pkg::result_type   res,
   input  logic                  res_ready
);
   import pmc_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int POS_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM);
   localparam int LVL_W  = $clog2(MAX_LEVELS);
   localparam int RAM_W  = NUM_CH * SUM_W;

   // level tables
   logic [DIM_W-1:0]  lw_ff   [MAX_LEVELS];
   logic [DIM_W-1:0]  lh_ff   [MAX_LEVELS];
   logic [ADDR_W-1:0] loff_ff [MAX_LEVELS];
   logic [LVL_W-1:0]  final_ff;

   // per-level position and pending column
   logic [POS_W-1:0] col_ff  [MAX_LEVELS];
   logic [POS_W-1:0] row_ff  [MAX_LEVELS];
   sum_type          pend_ff [MAX_LEVELS];

   // table set-up sequencer
   logic              drv_busy_ff, drv_found_ff;
   logic [LVL_W-1:0]  drv_idx_ff;
   logic [DIM_W-1:0]  drv_w_ff, drv_h_ff, drv_w_nx, drv_h_nx;
   logic [ADDR_W-1:0] drv_off_ff;
   logic [DIM_W:0]    drv_off_sum;

   back_state_type state_ff, state_in;
   pixel_type      cur_ff, nxt;
   logic [LVL_W-1:0] lvl_ff;
   logic           res_valid_ff;
   result_type     res_ff, res_in;

   // level datapath
   logic [DIM_W-1:0]  w, h;
   logic [POS_W-1:0]  col, row, ox;
   logic [DIM_W:0]    idx_sum;
   logic [ADDR_W-1:0] idx;
   logic              w_one, h_one, filt_en, hz_pair, made, done;
   logic              pend_wr, ram_wr, out_free, fire, accept;
   sum_type           hs, ram_q;
   logic [RAM_W-1:0]  ram_rd;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign busy = drv_busy_ff;

   // next level size during set-up: halve, never below one
   assign drv_w_nx    = (drv_w_ff > DIM_W'(1)) ? (drv_w_ff >> 1) : DIM_W'(1);
   assign drv_h_nx    = (drv_h_ff > DIM_W'(1)) ? (drv_h_ff >> 1) : DIM_W'(1);
   assign drv_off_sum = (DIM_W+1)'(drv_off_ff) + (DIM_W+1)'(drv_w_nx);

   // current level lookups
   assign w       = lw_ff[lvl_ff];
   assign h       = lh_ff[lvl_ff];
   assign col     = col_ff[lvl_ff];
   assign row     = row_ff[lvl_ff];
   assign w_one   = w == DIM_W'(1);
   assign h_one   = h == DIM_W'(1);
   assign filt_en = lvl_ff < final_ff;
   assign hz_pair = w_one || col[0];
   assign ox      = w_one ? '0 : (col >> 1);
   assign idx_sum = (DIM_W+1)'(loff_ff[lvl_ff]) + (DIM_W+1)'(ox);
   assign idx     = (idx_sum >= (DIM_W+1)'(MAX_DIM)) ?
                    ADDR_W'(idx_sum - (DIM_W+1)'(MAX_DIM)) : ADDR_W'(idx_sum);
   assign ram_q   = sum_type'(ram_rd);
   assign made    = filt_en && hz_pair && (h_one || row[0]);
   assign pend_wr = filt_en && !w_one && !col[0] &&
                    ((DIM_W'(col) + DIM_W'(1)) < w);
   assign ram_wr  = filt_en && hz_pair && !h_one && !row[0] &&
                    ((DIM_W'(row) + DIM_W'(1)) < h);
   assign done    = (lvl_ff == final_ff) && ((DIM_W'(col) + DIM_W'(1)) == w) &&
                    ((DIM_W'(row) + DIM_W'(1)) == h);
   assign out_free = !res_valid_ff || res_ready;
   assign fire     = (state_ff == BS_EMIT) && out_free;
   assign accept   = in_valid && in_ready;

   // horizontal pair sums and the next-level pixel
   always_comb begin
      logic [SUM_W:0] vs;
      for (int i = 0; i < NUM_CH; i++) begin
         if (w_one) begin
            hs[i] = {1'b0, cur_ff[i], 1'b0};
         end else begin
            hs[i] = pend_ff[lvl_ff][i] + SUM_W'(cur_ff[i]);
         end
         vs = (SUM_W+1)'(ram_q[i]) + (SUM_W+1)'(hs[i]);
         if (h_one) begin
            nxt[i] = CH_W'(hs[i] >> 1);
         end else begin
            nxt[i] = CH_W'(vs >> 2);
         end
      end
   end

   pmc_ram #(.WIDTH(RAM_W), .DEPTH(MAX_DIM)) u_row_pairs (
      .clock   (clock),
      .wr_en   (fire && ram_wr),
      .wr_addr (idx),
      .wr_data (RAM_W'(hs)),
      .rd_en   (state_ff == BS_LOOK),
      .rd_addr (idx),
      .rd_data (ram_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (accept) begin
               state_in = BS_LOOK;
            end
         end
         BS_LOOK: state_in = BS_EMIT;
         BS_EMIT: begin
            if (fire) begin
               state_in = made ? BS_LOOK : BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      in_ready           = (state_ff == BS_IDLE) && !drv_busy_ff;
      res_in.mip_level   = OUT_LEVEL_W'(lvl_ff);
      res_in.pixel_x     = OUT_POS_W'(col);
      res_in.pixel_y     = OUT_POS_W'(row);
      res_in.pixel       = cur_ff;
      res_in.last_of_run = !made;
      res_in.chain_done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            res_valid_ff <= 1'b1;
         end else if (res_ready) begin
            res_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         res_ff <= res_in;
      end
      if (accept) begin
         cur_ff <= in_pixel;
         lvl_ff <= '0;
      end else if (fire && made) begin
         cur_ff <= nxt;
         lvl_ff <= lvl_ff + LVL_W'(1);
      end
      if (fire && pend_wr) begin
         for (int i = 0; i < NUM_CH; i++) begin
            pend_ff[lvl_ff][i] <= SUM_W'(cur_ff[i]);
         end
      end
   end

   // advance level positions; restart on size change
   always_ff @(posedge clock) begin
      if (reset || size_cfg.restart) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (fire) begin
         if ((DIM_W'(col) + DIM_W'(1)) >= w) begin
            col_ff[lvl_ff] <= '0;
            if ((DIM_W'(row) + DIM_W'(1)) >= h) begin
               row_ff[lvl_ff] <= '0;
            end else begin
               row_ff[lvl_ff] <= row + POS_W'(1);
            end
         end else begin
            col_ff[lvl_ff] <= col + POS_W'(1);
         end
      end
   end

   // build the level tables, one level per cycle
   always_ff @(posedge clock) begin
      if (reset || size_cfg.restart) begin
         drv_busy_ff  <= 1'b1;
         drv_found_ff <= 1'b0;
         drv_idx_ff   <= '0;
         drv_off_ff   <= '0;
         drv_w_ff     <= reset ? DIM_W'(1) : clamp_dim(size_cfg.width);
         drv_h_ff     <= reset ? DIM_W'(1) : clamp_dim(size_cfg.height);
      end else if (drv_busy_ff) begin
         lw_ff[drv_idx_ff]   <= drv_w_ff;
         lh_ff[drv_idx_ff]   <= drv_h_ff;
         loff_ff[drv_idx_ff] <= drv_off_ff;
         if (!drv_found_ff && ((drv_w_ff == DIM_W'(1) && drv_h_ff == DIM_W'(1)) ||
                               drv_idx_ff == LVL_W'(MAX_LEVELS - 1))) begin
            final_ff     <= drv_idx_ff;
            drv_found_ff <= 1'b1;
         end
         drv_w_ff <= drv_w_nx;
         drv_h_ff <= drv_h_nx;
         drv_off_ff <= (drv_off_sum >= (DIM_W+1)'(MAX_DIM)) ?
                       ADDR_W'(drv_off_sum - (DIM_W+1)'(MAX_DIM)) : ADDR_W'(drv_off_sum);
         if (drv_idx_ff == LVL_W'(MAX_LEVELS - 1)) begin
            drv_busy_ff <= 1'b0;
         end else begin
            drv_idx_ff <= drv_idx_ff + LVL_W'(1);
         end
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;
endmodule

// ===== rtl/core/premultiply_and_mip_chain_core.sv =====
`timescale 1ns / 1ps
// Premultiplied-alpha mip chain core. Pixels of one image enter in raster
// order; each is returned as a level-0 result, optionally premultiplied, and
// also fed through a cascade of 2x2 box filters, each completed pixel of a
// deeper level following right after the result that completed it. A request
// enters the cascade sequencer, then each level it reaches takes one row-pair
// memory read and one emit; an emit waits while the response is not taken.
// The sequencer takes no new request until the last result of a run is emitted;
// it and the registered-read row-pair memory set the rate. After reset and after
// every image size write the core builds its level tables, with both
// request and register ports stalled.
module premultiply_and_mip_chain_core #(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pmc_pkg::CFG_DIM_W-1:0]     csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_in_red,
   input  logic [7:0]                        req_in_green,
   input  logic [7:0]                        req_in_blue,
   input  logic [7:0]                        req_in_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_mip_level,
   output logic [11:0]                       rsp_pixel_x,
   output logic [11:0]                       rsp_pixel_y,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic [7:0]                        rsp_out_alpha,
   output logic                              rsp_last_of_run,
   output logic                              rsp_chain_done
);
   import pmc_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic                 premul_ff;
   logic                 csr_fire, busy;
   size_cfg_type         size_cfg;
   pixel_type            req_pixel, f_pixel, q_pixel;
   logic                 f_valid, f_ready, q_valid, q_ready;
   result_type           res;

   assign csr_ready = !busy;
   assign csr_fire  = csr_valid && csr_ready;

   // size writes restart the image
   always_comb begin
      size_cfg.restart = csr_fire && (csr_index == CSR_IMAGE_WIDTH ||
                                      csr_index == CSR_IMAGE_HEIGHT);
      size_cfg.width   = (csr_index == CSR_IMAGE_WIDTH) ? csr_data : width_ff;
      size_cfg.height  = (csr_index == CSR_IMAGE_HEIGHT) ? csr_data : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(1);
         height_ff <= CFG_DIM_W'(1);
         premul_ff <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            CSR_PREMULTIPLY:  premul_ff <= csr_data[0];
            default:          ;
         endcase
      end
   end

   assign req_pixel = {req_in_alpha, req_in_blue, req_in_green, req_in_red};

   pmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .premultiply (premul_ff),
      .hold        (busy),
      .in_valid    (req_valid),
      .in_pixel    (req_pixel),
      .in_ready    (req_ready),
      .out_valid   (f_valid),
      .out_pixel   (f_pixel),
      .out_ready   (f_ready)
   );

   pmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_pixel  (f_pixel),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_pixel (q_pixel),
      .out_ready (q_ready)
   );

   pmc_back #(.MAX_DIM(MAX_DIM), .MAX_LEVELS(MAX_LEVELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .size_cfg  (size_cfg),
      .busy      (busy),
      .in_valid  (q_valid),
      .in_pixel  (q_pixel),
      .in_ready  (q_ready),
      .res_valid (rsp_valid),
      .res       (res),
      .res_ready (rsp_ready)
   );

   assign rsp_mip_level   = res.mip_level;
   assign rsp_pixel_x     = res.pixel_x;
   assign rsp_pixel_y     = res.pixel_y;
   assign rsp_out_red     = res.pixel[0];
   assign rsp_out_green   = res.pixel[1];
   assign rsp_out_blue    = res.pixel[2];
   assign rsp_out_alpha   = res.pixel[3];
   assign rsp_last_of_run = res.last_of_run;
   assign rsp_chain_done  = res.chain_done;

   // no request enters while the level tables are rebuilt
   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(req_valid && req_ready))
      else $error("request accepted during level table set-up");

   // the final level never feeds a further level
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chain_done) |-> rsp_last_of_run)
      else $error("chain_done result not last of its run");

   // a size write starts a table rebuild
   a_size_write_rebuilds: assert property (@(posedge clock) disable iff (reset)
      size_cfg.restart |=> busy)
      else $error("size write did not start level table set-up");

   // a deeper-level result flagged chain_done also ends its run
   a_level_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mip_level != 4'd0) |-> !rsp_chain_done || rsp_last_of_run)
      else $error("inconsistent result flags");
endmodule
